// ----- hdl/psa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg
// Types, codes and constants shared by the packet sample admission block.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int unsigned InterfaceCount = 1024;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned SamplerW       = 10;
  localparam int unsigned DivSteps       = 32;
  localparam int unsigned StepCntW       = 5;
  localparam logic [31:0] HalfRange      = 32'h7FFF_FFFF;
  localparam int unsigned MacHeader      = 14;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INGRESS_GROUP = 2'd0,
    CFG_EGRESS_GROUP  = 2'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    STAT_TAKEN    = 2'd0,
    STAT_FILTERED = 2'd1,
    STAT_UNKNOWN  = 2'd2,
    STAT_HELD     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_EVAL,
    S_ACC,
    S_OUT
  } fsm_state_e;

  typedef struct packed {
    logic [31:0]         group_number;
    logic [31:0]         group_sequence;
    logic [31:0]         raw_rate;
    logic                probability_flag;
    logic [14:0]         header_length;
    logic [31:0]         packet_length;
    logic [SamplerW-1:0] in_interface;
    logic [SamplerW-1:0] out_interface;
    logic                in_known;
    logic                out_known;
    logic [31:0]         in_conf_n;
    logic [31:0]         out_conf_n;
  } in_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [31:0]         effective_n;
    logic [31:0]         converted_rate;
    logic [30:0]         drop_count;
    logic                is_egress;
    logic [SamplerW-1:0] sampler_interface;
    logic [14:0]         payload_length;
    logic [31:0]         pdu_length;
  } out_req_t;

  typedef struct packed {
    logic clr_we;
    logic load;
    logic div_step;
    logic eval;
    logic commit;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } ctrl_sts_t;

endpackage

// ----- hdl/psa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer: memory clear sweep, divide iterations, evaluate, commit, output.
// ----------------------------------------------------------------------------
module psa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  psa_pkg::ctrl_sts_t  sts_i,
  output psa_pkg::ctrl_cmd_t  cmd_o
);
  import psa_pkg::*;

  fsm_state_e          state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + StepCntW'(1);
        if (cnt_q == StepCntW'(DivSteps - 1)) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_ACC;
      end
      S_ACC: begin
        cmd_o.commit = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/psa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_datapath
// Rate divider, interface index reduction, sequence tracking and the
// per-interface sub-sampling accumulator memory.
// ----------------------------------------------------------------------------
module psa_datapath #(
  parameter int unsigned INTERFACE_COUNT = psa_pkg::InterfaceCount
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  psa_pkg::ctrl_cmd_t           cmd_i,
  output psa_pkg::ctrl_sts_t           sts_o,
  input  logic                         cfg_we_i,
  input  logic [psa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  psa_pkg::in_req_t             in_req_i,
  output psa_pkg::out_req_t            out_req_o
);
  import psa_pkg::*;

  localparam int unsigned IdxW       = $clog2(INTERFACE_COUNT);
  localparam int unsigned RecipShift = SamplerW + IdxW;
  localparam int unsigned RecipW     = SamplerW + 2;
  localparam logic [63:0] RecipMul   =
    ((64'd1 << RecipShift) + 64'(INTERFACE_COUNT) - 64'd1) / 64'(INTERFACE_COUNT);

  // configuration and per-direction sequence
  logic [31:0] ing_group_q, egr_group_q;
  logic [31:0] last_seq_q [2];

  // item registers
  logic                grp_ok_q;
  logic                dir_q;
  logic [31:0]         seq_q;
  logic [31:0]         raw_rate_q;
  logic                prob_q;
  logic [14:0]         hlen_q;
  logic [31:0]         plen_q;
  logic [SamplerW-1:0] sampler_q;
  logic                known_q;
  logic [31:0]         conf_q;

  // divider and index reduction
  logic [31:0]                div_rem_q, div_quo_q;
  logic [32:0]                div_shift;
  logic                       div_ge;
  logic [SamplerW+RecipW-1:0] idx_prod;
  logic [SamplerW-1:0]        idx_quo;
  logic [31:0]                idx_rem;
  logic [IdxW-1:0]            acc_idx;

  // evaluation
  logic [31:0] rate_q;
  logic [30:0] drops_q;
  logic [31:0] seq_diff;
  logic        ld_hit_ing, ld_hit_egr;

  // accumulator memory
  logic [31:0]     acc_mem [INTERFACE_COUNT];
  logic [31:0]     acc_rdata_q;
  logic [IdxW-1:0] clr_addr_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [31:0]     mem_wdata;

  // commit
  logic [32:0] acc_sum;
  logic [31:0] acc_sat;
  logic        sub_en, take, admit, acc_we;
  out_req_t    res, res_q, out_q;

  assign ld_hit_ing = (in_req_i.group_number == ing_group_q);
  assign ld_hit_egr = (in_req_i.group_number == egr_group_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ing_group_q <= '0;
      egr_group_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_INGRESS_GROUP: ing_group_q <= cfg_data_i;
        CFG_EGRESS_GROUP:  egr_group_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      grp_ok_q   <= (in_req_i.group_number != '0) && (ld_hit_ing || ld_hit_egr);
      dir_q      <= ld_hit_egr;
      seq_q      <= in_req_i.group_sequence;
      raw_rate_q <= in_req_i.raw_rate;
      prob_q     <= in_req_i.probability_flag;
      hlen_q     <= in_req_i.header_length;
      plen_q     <= in_req_i.packet_length;
      sampler_q  <= ld_hit_egr ? in_req_i.out_interface : in_req_i.in_interface;
      known_q    <= ld_hit_egr ? in_req_i.out_known : in_req_i.in_known;
      conf_q     <= ld_hit_egr ? in_req_i.out_conf_n : in_req_i.in_conf_n;
    end
  end

  // restoring division of all ones by the raw rate
  assign div_shift = {div_rem_q, 1'b1};
  assign div_ge    = (div_shift >= {1'b0, raw_rate_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      div_rem_q <= '0;
      div_quo_q <= '0;
    end else if (cmd_i.div_step) begin
      div_rem_q <= div_ge ? 32'(div_shift - {1'b0, raw_rate_q}) : div_shift[31:0];
      div_quo_q <= {div_quo_q[30:0], div_ge};
    end
  end

  // sampler index modulo interface count by reciprocal multiply
  assign idx_prod = (SamplerW + RecipW)'(sampler_q) * RecipMul[SamplerW+RecipW-1:0];
  assign idx_quo  = SamplerW'(idx_prod >> RecipShift);
  assign idx_rem  = 32'(sampler_q) - 32'(idx_quo) * 32'(INTERFACE_COUNT);
  assign acc_idx  = IdxW'(idx_rem);

  assign seq_diff = seq_q - last_seq_q[dir_q] - 32'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      if (prob_q && (raw_rate_q != '0)) begin
        rate_q <= div_quo_q + {31'd0, (div_rem_q > HalfRange)};
      end else begin
        rate_q <= raw_rate_q;
      end
      if (last_seq_q[dir_q] == '0) begin
        drops_q <= '0;
      end else if (seq_diff[31]) begin
        drops_q <= 31'd1;
      end else begin
        drops_q <= seq_diff[30:0];
      end
    end
  end

  always_comb begin
    res      = '0;
    acc_sum  = {1'b0, acc_rdata_q} + {1'b0, rate_q};
    acc_sat  = acc_sum[32] ? '1 : acc_sum[31:0];
    sub_en   = (rate_q < conf_q);
    take     = !sub_en || (acc_sat >= conf_q);
    admit    = grp_ok_q && (hlen_q != '0) && (plen_q != '0) && (rate_q != '0);
    acc_we   = 1'b0;
    res.converted_rate = rate_q;
    if (!admit) begin
      res.status = STAT_FILTERED;
    end else begin
      res.is_egress         = dir_q;
      res.sampler_interface = sampler_q;
      res.drop_count        = drops_q;
      if (!known_q) begin
        res.status = STAT_UNKNOWN;
      end else if (!take) begin
        res.status = STAT_HELD;
        acc_we     = 1'b1;
      end else begin
        res.status         = STAT_TAKEN;
        acc_we             = sub_en;
        res.effective_n    = sub_en ? acc_sat : rate_q;
        res.payload_length = (hlen_q > 15'(MacHeader)) ? hlen_q - 15'(MacHeader) : '0;
        res.pdu_length     = (plen_q > 32'(MacHeader)) ? plen_q - 32'(MacHeader) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q[0] <= '0;
      last_seq_q[1] <= '0;
    end else if (cmd_i.commit && admit) begin
      last_seq_q[dir_q] <= seq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q <= res;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_addr_q <= clr_addr_q + IdxW'(1);
    end
  end

  assign sts_o.clr_last = (clr_addr_q == IdxW'(INTERFACE_COUNT - 1));

  assign mem_we    = cmd_i.clr_we || (cmd_i.commit && acc_we);
  assign mem_waddr = cmd_i.clr_we ? clr_addr_q : acc_idx;
  assign mem_wdata = (cmd_i.clr_we || take) ? '0 : acc_sat;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      acc_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.eval) begin
      acc_rdata_q <= acc_mem[acc_idx];
    end
  end

  assign out_req_o = out_q;

endmodule

// ----- hdl/packet_sample_admission.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_sample_admission
// Admits decoded packet samples, converts probability rates, tracks drops
// and applies per-interface sub-sampling.
// ----------------------------------------------------------------------------
// flow: a request runs the 32-step radix-2 divider, evaluate, commit and
//   output; the next request is accepted only after this one is output
// reset: control, configuration and sequence registers cleared at once, then
//   every accumulator memory entry is cleared, one per cycle, input stalled
// ----------------------------------------------------------------------------
module packet_sample_admission #(
  parameter int unsigned INTERFACE_COUNT = psa_pkg::InterfaceCount
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  psa_pkg::in_req_t             in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output psa_pkg::out_req_t            out_req_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [psa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);
  import psa_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  psa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  psa_datapath #(
    .INTERFACE_COUNT (INTERFACE_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (in_req_i),
    .out_req_o   (out_req_o)
  );

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one still in work");

  a_untaken_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.status != STAT_TAKEN) |->
      (out_req_o.effective_n == '0) && (out_req_o.payload_length == '0) &&
      (out_req_o.pdu_length == '0))
    else $error("lengths or n set on a result that was not taken");

  a_filtered_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.status == STAT_FILTERED) |->
      (out_req_o.drop_count == '0) && !out_req_o.is_egress &&
      (out_req_o.sampler_interface == '0))
    else $error("direction fields set on a filtered result");

endmodule
